// ===== rtl/indexed_list_insert_remove_defines.svh =====
// ----------------------------------------------------------------------------
// Indexed list assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH

`ifndef SYNTHESIS
`define ILIR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("indexed list: same-cycle check failed");
`define ILIR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("indexed list: next-cycle check failed");
`else
`define ILIR_ASSERT_IMP(label, clk, rst, ante, cons)
`define ILIR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/ilir_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed list package
// Field widths, command and status codes, cell operations.
// ----------------------------------------------------------------------------
`default_nettype none

package ilir_pkg;

   localparam int CMD_W    = 3;
   localparam int INDEX_W  = 5;
   localparam int VALUE_W  = 32;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // position arithmetic width, covers a count of up to 256
   localparam int POS_W = 9;

   localparam int DEFAULT_DEPTH       = 16;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_START  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_INSERT = 2'd2;
   localparam logic [1:0] OP_REMOVE = 2'd3;

   typedef struct packed {
      logic [1:0]       op;
      logic [POS_W-1:0] pos;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/ilir_req_if.sv =====
// ----------------------------------------------------------------------------
// Indexed list request channel
// Valid/ready channel carrying one list command.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilir_req_if;
   import ilir_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [INDEX_W-1:0] index;
   logic [VALUE_W-1:0] value;

   modport source (output valid, cmd, index, value, input ready);
   modport sink   (input valid, cmd, index, value, output ready);
endinterface

`default_nettype wire

// ===== rtl/ilir_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Indexed list response channel
// Valid/ready channel carrying one command result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilir_rsp_if;
   import ilir_pkg::*;

   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   data;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, data, status, count, input ready);
   modport sink   (input valid, data, status, count, output ready);
endinterface

`default_nettype wire

// ===== rtl/ilir_cell.sv =====
// ----------------------------------------------------------------------------
// Indexed list cell
// One list slot: write, take from lower or upper neighbor, or hold.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_cell #(
   parameter int VALUE_WIDTH = 32,
   parameter int POS         = 0
) (
   input  wire logic                      clock,
   input  wire ilir_pkg::cell_cmd_type    cmd,
   input  wire logic [VALUE_WIDTH-1:0]    wr_value,
   input  wire logic [VALUE_WIDTH-1:0]    lower_value,
   input  wire logic [VALUE_WIDTH-1:0]    upper_value,
   input  wire logic [ilir_pkg::POS_W-1:0] rd_pos,
   output logic      [VALUE_WIDTH-1:0]    value,
   output logic      [VALUE_WIDTH-1:0]    rd_value
);
   import ilir_pkg::*;

   localparam logic [POS_W-1:0] MyPos = POS_W'(POS);

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         OP_SET: begin
            if (MyPos == cmd.pos) value_in = wr_value;
         end
         OP_INSERT: begin
            if (MyPos == cmd.pos) value_in = wr_value;
            else if (MyPos > cmd.pos) value_in = lower_value;
         end
         OP_REMOVE: begin
            if (MyPos >= cmd.pos) value_in = upper_value;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   assign rd_value = (rd_pos == MyPos) ? value_ff : '0;
endmodule

`default_nettype wire

// ===== rtl/ilir_chain.sv =====
// ----------------------------------------------------------------------------
// Indexed list cell chain
// Row of cells linked to their neighbors, with a selected read.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_chain #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire ilir_pkg::cell_cmd_type     cmd,
   input  wire logic [VALUE_WIDTH-1:0]     wr_value,
   input  wire logic [ilir_pkg::POS_W-1:0] rd_pos,
   output logic      [VALUE_WIDTH-1:0]     rd_value
);
   import ilir_pkg::*;

   logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic [VALUE_WIDTH-1:0] cell_rd    [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [VALUE_WIDTH-1:0] lower_w;
      logic [VALUE_WIDTH-1:0] upper_w;

      if (g == 0) begin : g_first
         assign lower_w = '0;
      end else begin : g_mid_lo
         assign lower_w = cell_value[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign upper_w = '0;
      end else begin : g_mid_hi
         assign upper_w = cell_value[g+1];
      end

      ilir_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .POS         (g)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .wr_value    (wr_value),
         .lower_value (lower_w),
         .upper_value (upper_w),
         .rd_pos      (rd_pos),
         .value       (cell_value[g]),
         .rd_value    (cell_rd[g])
      );
   end

   // at most one cell matches rd_pos
   always_comb begin
      rd_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_value = rd_value | cell_rd[i];
      end
   end
endmodule

`default_nettype wire

// ===== rtl/indexed_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// Indexed list with insert and remove
// Ordered list of up to DEPTH values in a shifting chain of cells.
// ----------------------------------------------------------------------------
//  channel  | dir | fields                      | handshake
//  req_bus  | in  | cmd[3] index[5] value[32]   | valid/ready
//  rsp_bus  | out | data[32] status[2] count[5] | valid/ready
//
//  A request is done when accepted: the cell chain shifts all entries at once
//  and the result lands in the response register on the accepting edge.
//  A new request is taken whenever the response register is empty or is
//  being read in the same cycle, so one request per cycle when unstalled.
//  Reset clears count, cursor and response valid; cell contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_list_insert_remove_defines.svh"

module indexed_list_insert_remove #(
   parameter int DEPTH       = ilir_pkg::DEFAULT_DEPTH,
   parameter int VALUE_WIDTH = ilir_pkg::DEFAULT_VALUE_WIDTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ilir_req_if.sink    req_bus,
   ilir_rsp_if.source  rsp_bus
);
   import ilir_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [CW-1:0]       cursor_ff;
   logic [CW-1:0]       cursor_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff;
   logic [DATA_W-1:0]   rsp_data_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                   fire;
   logic [POS_W-1:0]       idx_w;
   logic [POS_W-1:0]       cnt_w;
   logic [POS_W-1:0]       cur_w;
   logic [POS_W-1:0]       rd_pos;
   logic                   in_range;
   logic [VALUE_WIDTH-1:0] wr_value;
   logic [VALUE_WIDTH-1:0] rd_value;
   cell_cmd_type           cell_cmd;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = req_bus.valid && req_bus.ready;

   assign idx_w    = POS_W'(req_bus.index);
   assign cnt_w    = POS_W'(count_ff);
   assign cur_w    = POS_W'(cursor_ff);
   assign in_range = idx_w < cnt_w;
   assign rd_pos   = (req_bus.cmd == CMD_NEXT) ? cur_w : idx_w;
   assign wr_value = VALUE_WIDTH'(req_bus.value);

   always_comb begin
      cell_cmd.op   = OP_HOLD;
      cell_cmd.pos  = idx_w;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      rsp_data_in   = '0;
      rsp_status_in = ST_OK;
      case (req_bus.cmd)
         CMD_GET: begin
            if (in_range) rsp_data_in = DATA_W'(rd_value);
            else rsp_status_in = ST_RANGE;
         end
         CMD_SET: begin
            if (in_range) cell_cmd.op = OP_SET;
            else rsp_status_in = ST_RANGE;
         end
         CMD_INSERT: begin
            if (idx_w > cnt_w) begin
               rsp_status_in = ST_RANGE;
            end else if (cnt_w == POS_W'(DEPTH)) begin
               rsp_status_in = ST_FULL;
            end else begin
               cell_cmd.op = OP_INSERT;
               count_in    = count_ff + 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (in_range) begin
               rsp_data_in = DATA_W'(rd_value);
               cell_cmd.op = OP_REMOVE;
               count_in    = count_ff - 1'b1;
            end else begin
               rsp_status_in = ST_RANGE;
            end
         end
         CMD_CLEAR: count_in = '0;
         CMD_START: cursor_in = '0;
         CMD_NEXT: begin
            if (cur_w < cnt_w) begin
               rsp_data_in = DATA_W'(rd_value);
               cursor_in   = cursor_ff + 1'b1;
            end else begin
               rsp_status_in = ST_RANGE;
            end
         end
         default: rsp_status_in = ST_OK;
      endcase
      if (!fire) cell_cmd.op = OP_HOLD;
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_bus.ready);

   ilir_chain #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_chain (
      .clock    (clock),
      .cmd      (cell_cmd),
      .wr_value (wr_value),
      .rd_pos   (rd_pos),
      .rd_value (rd_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff  <= count_in;
            cursor_ff <= cursor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= COUNT_W'(count_in);
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.data   = rsp_data_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.count  = rsp_count_ff;

   `ILIR_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `ILIR_ASSERT_NXT(a_fire_rsp, clock, reset, fire, rsp_valid_ff)
   `ILIR_ASSERT_IMP(a_rsp_count, clock, reset, rsp_valid_ff, rsp_count_ff == COUNT_W'(count_ff))
   `ILIR_ASSERT_IMP(a_full_count, clock, reset, rsp_valid_ff && rsp_status_ff == ST_FULL, count_ff == CW'(DEPTH))
endmodule

`default_nettype wire
